// ----- rtl/sts_pkg.sv -----
// Shared types, character codes and lookup functions for the script token scanner.
// Holds the token kind codes, the keyword table and the operator tables.
// No dependencies.
`default_nettype none

package sts_pkg;

	typedef enum logic [5:0] {
		K_END = 6'd0, K_IDENT, K_INT, K_FLOAT, K_STRING, K_BOOL,
		K_ADD, K_ADD_EQ, K_SUB, K_SUB_EQ, K_MUL, K_MUL_EQ, K_DIV, K_DIV_EQ,
		K_ASSIGN, K_EQ, K_AND, K_OR, K_PIPE, K_PIPE_NOT, K_GT, K_GE, K_LT, K_LE,
		K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK,
		K_COLON, K_DOT, K_NOT, K_VAR, K_FUNC, K_IF, K_ELSE, K_ELIF, K_TYPE,
		K_INCLUDE, K_RETURN, K_BREAK, K_CONTINUE, K_VEC2, K_VEC3, K_VEC4,
		K_CONST, K_FOR, K_WHILE, K_IN, K_NULL
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [19:0] line;
		logic [15:0] col;
		logic [7:0]  len;
	} token_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] len;
	} tok_attr_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} op_hit_t;

	typedef struct packed {
		logic [63:0] text;   // right-aligned, first character in the highest used byte
		logic [3:0]  len;
		kind_t       kind;
		logic [3:0]  outlen;
	} kw_t;

	localparam int KW_COUNT = 23;
	localparam int KW_MAX_CHARS = 8;

	localparam kw_t KW_TABLE [KW_COUNT] = '{
		'{64'("var"),      4'd3, K_VAR,      4'd3},
		'{64'("func"),     4'd4, K_FUNC,     4'd4},
		'{64'("if"),       4'd2, K_IF,       4'd2},
		'{64'("else"),     4'd4, K_ELSE,     4'd4},
		'{64'("elif"),     4'd4, K_ELIF,     4'd4},
		'{64'("and"),      4'd3, K_AND,      4'd2},
		'{64'("or"),       4'd2, K_OR,       4'd2},
		'{64'("type"),     4'd4, K_TYPE,     4'd4},
		'{64'("include"),  4'd7, K_INCLUDE,  4'd7},
		'{64'("return"),   4'd6, K_RETURN,   4'd6},
		'{64'("break"),    4'd5, K_BREAK,    4'd5},
		'{64'("continue"), 4'd8, K_CONTINUE, 4'd8},
		'{64'("Vector2"),  4'd7, K_VEC2,     4'd7},
		'{64'("Vector3"),  4'd7, K_VEC3,     4'd7},
		'{64'("Vector4"),  4'd7, K_VEC4,     4'd7},
		'{64'("true"),     4'd4, K_BOOL,     4'd4},
		'{64'("false"),    4'd5, K_BOOL,     4'd5},
		'{64'("const"),    4'd5, K_CONST,    4'd5},
		'{64'("for"),      4'd3, K_FOR,      4'd3},
		'{64'("while"),    4'd5, K_WHILE,    4'd5},
		'{64'("in"),       4'd2, K_IN,       4'd2},
		'{64'("null"),     4'd4, K_NULL,     4'd4},
		'{64'("not"),      4'd3, K_NOT,      4'd3}
	};

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_HASH   = "#";
	localparam logic [7:0] CH_QUOTE  = "\"";
	localparam logic [7:0] CH_UNDER  = "_";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_EQ     = "=";
	localparam logic [7:0] CH_AMP    = "&";
	localparam logic [7:0] CH_BAR    = "|";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_LT     = "<";
	localparam logic [7:0] CH_BANG   = "!";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_COLON  = ":";

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_op_start(logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
			(c == CH_EQ) || (c == CH_AMP) || (c == CH_BAR) || (c == CH_GT) ||
			(c == CH_LT);
	endfunction

	// One-character operator left pending when no second character follows.
	function automatic op_hit_t op_single(logic [7:0] f);
		op_hit_t r;
		r.hit  = 1'b1;
		r.kind = K_END;
		unique case (f)
			CH_PLUS:  r.kind = K_ADD;
			CH_MINUS: r.kind = K_SUB;
			CH_STAR:  r.kind = K_MUL;
			CH_SLASH: r.kind = K_DIV;
			CH_EQ:    r.kind = K_ASSIGN;
			CH_BAR:   r.kind = K_PIPE;
			CH_GT:    r.kind = K_GT;
			CH_LT:    r.kind = K_LT;
			default:  r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic op_hit_t op_pair(logic [7:0] f, logic [7:0] c);
		op_hit_t r;
		r.hit  = 1'b0;
		r.kind = K_END;
		if (c == CH_EQ) begin
			r.hit = 1'b1;
			unique case (f)
				CH_PLUS:  r.kind = K_ADD_EQ;
				CH_MINUS: r.kind = K_SUB_EQ;
				CH_STAR:  r.kind = K_MUL_EQ;
				CH_SLASH: r.kind = K_DIV_EQ;
				CH_EQ:    r.kind = K_EQ;
				CH_GT:    r.kind = K_GE;
				CH_LT:    r.kind = K_LE;
				default:  r.hit  = 1'b0;
			endcase
		end else if ((f == CH_AMP) && (c == CH_AMP)) begin
			r.hit  = 1'b1;
			r.kind = K_AND;
		end else if ((f == CH_BAR) && (c == CH_BAR)) begin
			r.hit  = 1'b1;
			r.kind = K_OR;
		end else if ((f == CH_BAR) && (c == CH_BANG)) begin
			r.hit  = 1'b1;
			r.kind = K_PIPE_NOT;
		end
		return r;
	endfunction

	// Punctuation that forms a token by itself.
	function automatic op_hit_t punct_kind(logic [7:0] c);
		op_hit_t r;
		r.hit  = 1'b1;
		r.kind = K_END;
		unique case (c)
			CH_LPAREN: r.kind = K_LPAREN;
			CH_RPAREN: r.kind = K_RPAREN;
			CH_LBRACE: r.kind = K_LBRACE;
			CH_RBRACE: r.kind = K_RBRACE;
			CH_LBRACK: r.kind = K_LBRACK;
			CH_RBRACK: r.kind = K_RBRACK;
			CH_COLON:  r.kind = K_COLON;
			CH_DOT:    r.kind = K_DOT;
			CH_BANG:   r.kind = K_NOT;
			default:   r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	// Compare the first eight name bytes against every keyword at once.
	function automatic tok_attr_t kw_lookup(logic [63:0] name8, logic [7:0] tlen);
		tok_attr_t r;
		logic      hit;
		r.kind = K_IDENT;
		r.len  = tlen;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (tlen == {4'd0, KW_TABLE[k].len});
			for (int i = 0; i < KW_MAX_CHARS; i++) begin
				if (i < int'(KW_TABLE[k].len)) begin
					if (name8[8*i +: 8] !=
						KW_TABLE[k].text[8*(int'(KW_TABLE[k].len) - 1 - i) +: 8])
						hit = 1'b0;
				end
			end
			if (hit) begin
				r.kind = KW_TABLE[k].kind;
				r.len  = {4'd0, KW_TABLE[k].outlen};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/script_token_scanner_top.sv -----
// Script token scanner: turns a byte stream of source text into a token stream.
// Depends on sts_pkg (kind codes, keyword and operator tables).
//
// Usage:
//   Input stream s_*: one source byte per beat in s_tdata[7:0]; s_tlast marks
//   the final byte of a text. Output stream m_*: one token per beat with kind,
//   line and column of its first character and its text length; m_tlast marks
//   the last token caused by one input byte.
//   An input beat lands in an input register; once the result register drains,
//   one pass of logic classifies it, updates the scan state and writes zero to
//   three tokens into a four-slot result register, from which m_* shows the
//   first token. A byte that yields at most one token leaves room for a new
//   byte every cycle while the receiver accepts, so ordinary text then runs at
//   one byte per clock; a byte that yields more tokens holds the input side
//   while the result register drains one token per beat.
//   When the receiver stalls, the result register holds and the input register
//   fills; s_tready drops once both are occupied. The final byte of a text also
//   emits an end token and returns the scanner to line 1, column 0.
//   Reset clears all control state; the scanner then starts at line 1, column 0.
`default_nettype none

module script_token_scanner_top
	import sts_pkg::*;
#(
	parameter int KEYWORD_CHARS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [5:0] token_kind, [25:6] start_line,
	                                    // [41:26] start_column, [49:42] lexeme_length
	output logic             m_tlast    // run_last
);

	localparam int IDXW = $clog2(KEYWORD_CHARS);
	localparam logic [19:0] LINE_MAX = '1;
	localparam logic [15:0] COL_MAX  = '1;
	localparam logic [7:0]  LEN_MAX  = '1;

	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_NUM     = 6'b000010,
		M_NAME    = 6'b000100,
		M_STR     = 6'b001000,
		M_COMMENT = 6'b010000,
		M_OP      = 6'b100000
	} mode_t;

	// input register
	logic       s1_valid;
	logic [7:0] char_s1;
	logic       eot_s1;

	// scan state
	mode_t       mode_q, mode_d;
	logic [7:0]  pfc_q, pfc_d;
	logic [7:0]  tl_q, tl_d;
	logic        dot_q, dot_d;
	logic [19:0] line_q, line_d;
	logic [15:0] col_q, col_d;
	logic [19:0] tline_q, tline_d;
	logic [15:0] tcol_q, tcol_d;
	logic [7:0]  name_q [KEYWORD_CHARS];

	logic            nb_we;
	logic [IDXW-1:0] nb_idx;
	logic [63:0]     name8_q, name8_d;

	// result register: slots for mode flush, start token, final flush, end token
	token_t     res_q [4];
	logic [3:0] resv_q;
	token_t     tok_d [4];
	logic [3:0] tokv_d;

	logic       adv, pop;
	logic [3:0] first_oh, resv_pop;
	logic [1:0] sel;
	token_t     head;

	always_comb begin
		for (int i = 0; i < KW_MAX_CHARS; i++) begin
			name8_q[8*i +: 8] = (i < KEYWORD_CHARS) ? name_q[i] : 8'd0;
			name8_d[8*i +: 8] = (nb_we && (int'(nb_idx) == i)) ? char_s1 : name8_q[8*i +: 8];
		end
	end

	always_comb begin
		logic [19:0] ln;
		logic [15:0] cl;
		logic        used;
		logic [7:0]  tl_inc;
		op_hit_t     oh;
		tok_attr_t   ta;

		mode_d  = mode_q;
		pfc_d   = pfc_q;
		tl_d    = tl_q;
		dot_d   = dot_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		nb_we   = 1'b0;
		nb_idx  = tl_q[IDXW-1:0];
		used    = 1'b0;
		tokv_d  = 4'd0;
		tl_inc  = tl_q + {7'd0, (tl_q != LEN_MAX)};
		oh.hit  = 1'b0;
		oh.kind = K_END;
		ta.kind = K_IDENT;
		ta.len  = 8'd0;
		for (int i = 0; i < 4; i++) begin
			tok_d[i].kind = K_END;
			tok_d[i].line = 20'd0;
			tok_d[i].col  = 16'd0;
			tok_d[i].len  = 8'd0;
		end

		// position of this byte; a newline sits at column 0 of the next line
		if (char_s1 == CH_NL) begin
			line_d = line_q + {19'd0, (line_q != LINE_MAX)};
			ln     = line_d;
			cl     = 16'd0;
			col_d  = 16'd1;
		end else begin
			line_d = line_q;
			ln     = line_q;
			cl     = col_q;
			col_d  = col_q + {15'd0, (col_q != COL_MAX)};
		end

		tok_d[0].line = tline_q;
		tok_d[0].col  = tcol_q;
		unique case (mode_q)
			M_NUM: begin
				if (is_digit(char_s1)) begin
					tl_d = tl_inc;
					used = 1'b1;
				end else if ((char_s1 == CH_DOT) && !dot_q) begin
					dot_d = 1'b1;
					tl_d  = tl_inc;
					used  = 1'b1;
				end else begin
					tokv_d[0]     = 1'b1;
					tok_d[0].kind = dot_q ? K_FLOAT : K_INT;
					tok_d[0].len  = tl_q;
					mode_d        = M_IDLE;
				end
			end
			M_NAME: begin
				if (is_alpha(char_s1) || is_digit(char_s1) || (char_s1 == CH_UNDER)) begin
					nb_we = (tl_q < 8'(KEYWORD_CHARS));
					tl_d  = tl_inc;
					used  = 1'b1;
				end else begin
					ta            = kw_lookup(name8_q, tl_q);
					tokv_d[0]     = 1'b1;
					tok_d[0].kind = ta.kind;
					tok_d[0].len  = ta.len;
					mode_d        = M_IDLE;
				end
			end
			M_STR: begin
				if (char_s1 == CH_QUOTE) begin
					tokv_d[0]     = 1'b1;
					tok_d[0].kind = K_STRING;
					tok_d[0].len  = tl_q;
					mode_d        = M_IDLE;
				end else begin
					tl_d = tl_inc;
				end
				used = 1'b1;
			end
			M_COMMENT: begin
				if (char_s1 == CH_NL)
					mode_d = M_IDLE;
				used = 1'b1;
			end
			M_OP: begin
				oh = op_pair(pfc_q, char_s1);
				if (oh.hit) begin
					tokv_d[0]     = 1'b1;
					tok_d[0].kind = oh.kind;
					tok_d[0].len  = 8'd2;
					used          = 1'b1;
				end else begin
					oh            = op_single(pfc_q);
					tokv_d[0]     = oh.hit;
					tok_d[0].kind = oh.kind;
					tok_d[0].len  = 8'd1;
				end
				mode_d = M_IDLE;
			end
			default: mode_d = M_IDLE;
		endcase

		// byte not taken by a pending token starts a new one
		if (!used) begin
			tline_d = ln;
			tcol_d  = cl;
			oh      = punct_kind(char_s1);
			priority if (is_space(char_s1)) begin
				mode_d = mode_d;
			end else if (is_digit(char_s1)) begin
				mode_d = M_NUM;
				tl_d   = 8'd1;
				dot_d  = 1'b0;
			end else if (is_alpha(char_s1) || (char_s1 == CH_UNDER)) begin
				mode_d = M_NAME;
				nb_we  = 1'b1;
				nb_idx = '0;
				tl_d   = 8'd1;
			end else if (char_s1 == CH_HASH) begin
				mode_d = M_COMMENT;
			end else if (char_s1 == CH_QUOTE) begin
				mode_d = M_STR;
				tl_d   = 8'd0;
			end else if (is_op_start(char_s1)) begin
				mode_d = M_OP;
				pfc_d  = char_s1;
			end else begin
				tokv_d[1]     = oh.hit;
				tok_d[1].kind = oh.kind;
				tok_d[1].line = ln;
				tok_d[1].col  = cl;
				tok_d[1].len  = 8'd1;
			end
		end

		// final byte: flush what is pending, add the end token, then restart
		if (eot_s1) begin
			tok_d[2].line = tline_d;
			tok_d[2].col  = tcol_d;
			unique case (mode_d)
				M_NUM: begin
					tokv_d[2]     = 1'b1;
					tok_d[2].kind = dot_d ? K_FLOAT : K_INT;
					tok_d[2].len  = tl_d;
				end
				M_NAME: begin
					ta            = kw_lookup(name8_d, tl_d);
					tokv_d[2]     = 1'b1;
					tok_d[2].kind = ta.kind;
					tok_d[2].len  = ta.len;
				end
				M_STR: begin
					tokv_d[2]     = 1'b1;
					tok_d[2].kind = K_STRING;
					tok_d[2].len  = tl_d;
				end
				M_OP: begin
					oh            = op_single(pfc_d);
					tokv_d[2]     = oh.hit;
					tok_d[2].kind = oh.kind;
					tok_d[2].len  = 8'd1;
				end
				default: tokv_d[2] = 1'b0;
			endcase
			tokv_d[3]     = 1'b1;
			tok_d[3].kind = K_END;
			tok_d[3].line = line_d;
			tok_d[3].col  = col_d;
			tok_d[3].len  = 8'd0;
			mode_d  = M_IDLE;
			pfc_d   = 8'd0;
			tl_d    = 8'd0;
			dot_d   = 1'b0;
			line_d  = 20'd1;
			col_d   = 16'd0;
			tline_d = 20'd0;
			tcol_d  = 16'd0;
		end
	end

	// output side: present the lowest occupied slot
	assign first_oh = resv_q & (~resv_q + 4'd1);
	assign pop      = m_tvalid && m_tready;
	assign resv_pop = pop ? (resv_q & ~first_oh) : resv_q;
	assign adv      = s1_valid && (resv_pop == 4'd0);
	assign s_tready = !s1_valid || adv;

	always_comb begin
		priority if (resv_q[0]) sel = 2'd0;
		else if (resv_q[1])     sel = 2'd1;
		else if (resv_q[2])     sel = 2'd2;
		else                    sel = 2'd3;
	end

	assign head     = res_q[sel];
	assign m_tvalid = (resv_q != 4'd0);
	assign m_tlast  = ((resv_q & (resv_q - 4'd1)) == 4'd0);
	assign m_tdata  = {6'd0, head.len, head.col, head.line, head.kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pfc_q   <= 8'd0;
			tl_q    <= 8'd0;
			dot_q   <= 1'b0;
			line_q  <= 20'd1;
			col_q   <= 16'd0;
			tline_q <= 20'd0;
			tcol_q  <= 16'd0;
			resv_q  <= 4'd0;
		end else begin
			if (adv) begin
				mode_q  <= mode_d;
				pfc_q   <= pfc_d;
				tl_q    <= tl_d;
				dot_q   <= dot_d;
				line_q  <= line_d;
				col_q   <= col_d;
				tline_q <= tline_d;
				tcol_q  <= tcol_d;
				resv_q  <= tokv_d;
			end else begin
				resv_q  <= resv_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				res_q[i] <= tok_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nb_we)
			name_q[nb_idx] <= char_s1;
	end

	// final byte leaves the end token in the last slot
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && eot_s1 |=> resv_q[3] && (res_q[3].kind == K_END))
		else $error("end token missing after final byte");

	// final byte restarts position and mode
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && eot_s1 |=> (line_q == 20'd1) && (col_q == 16'd0) && (mode_q == M_IDLE))
		else $error("scanner not restarted after final byte");

	// one byte never yields four tokens
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(resv_q) <= 3)
		else $error("more than three tokens from one byte");

	// slots only drain between loads
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ((resv_q & ~$past(resv_q)) == 4'd0))
		else $error("result slot set without a load");

	// a pending name always holds at least one character
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_NAME) |-> (tl_q != 8'd0))
		else $error("empty pending name");

endmodule

`default_nettype wire

// ----- sim/script_token_scanner_top_tb.sv -----
// Testbench for script_token_scanner_top: drives source bytes on the s_* stream and
// checks every token on the m_* stream against a scanner model kept in this file.
// Depends on sts_pkg for the token kind codes and on the RTL of the scanner.
`default_nettype none

module script_token_scanner_top_tb
	import sts_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_KEEP = 8;
	localparam int KEYWORD_COUNT = 23;
	localparam int OP_COUNT = 20;
	localparam int TIMEOUT_NS = 200_000;
	localparam logic [7:0] NL = 8'h0A;

	typedef enum logic [2:0] {
		SC_IDLE, SC_NUMBER, SC_NAME, SC_STRING, SC_COMMENT, SC_OPERATOR
	} scan_t;

	typedef struct {
		kind_t       kind;
		logic [19:0] line;
		logic [15:0] col;
		logic [7:0]  len;
		logic        last;
	} token_exp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] char_code
	logic        s_tlast;    // end_of_text
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;    // [5:0] token_kind, [25:6] start_line,
	                         // [41:26] start_column, [49:42] lexeme_length
	logic        m_tlast;    // run_last

	// scanner state as the block should hold it
	scan_t       mode;
	logic [7:0]  op_first;
	logic [7:0]  name_chars [NAME_KEEP];
	logic [7:0]  tok_len;
	logic        dot_seen;
	logic [19:0] cur_line;
	logic [15:0] cur_col;
	logic [19:0] tok_line;
	logic [15:0] tok_col;

	token_exp_t  token_q [$];
	logic [7:0]  text_q [$];
	int          fail_count;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;

	script_token_scanner_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------- scanner model ----------------

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void keyword_entry(input int i, output string txt, output kind_t k);
		case (i)
			0:  begin txt = "var";      k = K_VAR;      end
			1:  begin txt = "func";     k = K_FUNC;     end
			2:  begin txt = "if";       k = K_IF;       end
			3:  begin txt = "else";     k = K_ELSE;     end
			4:  begin txt = "elif";     k = K_ELIF;     end
			5:  begin txt = "and";      k = K_AND;      end
			6:  begin txt = "or";       k = K_OR;       end
			7:  begin txt = "type";     k = K_TYPE;     end
			8:  begin txt = "include";  k = K_INCLUDE;  end
			9:  begin txt = "return";   k = K_RETURN;   end
			10: begin txt = "break";    k = K_BREAK;    end
			11: begin txt = "continue"; k = K_CONTINUE; end
			12: begin txt = "Vector2";  k = K_VEC2;     end
			13: begin txt = "Vector3";  k = K_VEC3;     end
			14: begin txt = "Vector4";  k = K_VEC4;     end
			15: begin txt = "true";     k = K_BOOL;     end
			16: begin txt = "false";    k = K_BOOL;     end
			17: begin txt = "const";    k = K_CONST;    end
			18: begin txt = "for";      k = K_FOR;      end
			19: begin txt = "while";    k = K_WHILE;    end
			20: begin txt = "in";       k = K_IN;       end
			21: begin txt = "null";     k = K_NULL;     end
			default: begin txt = "not"; k = K_NOT;      end
		endcase
	endfunction

	function automatic logic single_op(input logic [7:0] f, output kind_t k);
		k = K_END;
		case (f)
			"+": k = K_ADD;
			"-": k = K_SUB;
			"*": k = K_MUL;
			"/": k = K_DIV;
			"=": k = K_ASSIGN;
			"|": k = K_PIPE;
			">": k = K_GT;
			"<": k = K_LT;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic pair_op(input logic [7:0] f, input logic [7:0] c, output kind_t k);
		k = K_END;
		if (c == "=") begin
			case (f)
				"+": k = K_ADD_EQ;
				"-": k = K_SUB_EQ;
				"*": k = K_MUL_EQ;
				"/": k = K_DIV_EQ;
				"=": k = K_EQ;
				">": k = K_GE;
				"<": k = K_LE;
				default: return 1'b0;
			endcase
			return 1'b1;
		end
		if (f == "&" && c == "&") k = K_AND;
		else if (f == "|" && c == "|") k = K_OR;
		else if (f == "|" && c == "!") k = K_PIPE_NOT;
		else return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic punct_token(input logic [7:0] c, output kind_t k);
		k = K_END;
		case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			":": k = K_COLON;
			".": k = K_DOT;
			"!": k = K_NOT;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void clear_scanner();
		mode = SC_IDLE;
		op_first = 8'd0;
		tok_len = 8'd0;
		dot_seen = 1'b0;
		cur_line = 20'd1;
		cur_col = 16'd0;
		tok_line = 20'd0;
		tok_col = 16'd0;
	endfunction

	function automatic void push_token(input kind_t k, input logic [19:0] ln,
		input logic [15:0] cl, input logic [7:0] n);
		token_exp_t t;
		t.kind = k;
		t.line = ln;
		t.col = cl;
		t.len = n;
		t.last = 1'b0;
		token_q.insert(token_q.size(), t);
	endfunction

	function automatic void bump_len();
		if (tok_len != 8'hFF) tok_len++;
	endfunction

	function automatic void finish_name();
		string       txt;
		kind_t       k;
		logic        hit;
		kind_t       found;
		logic [7:0]  out_len;
		found = K_IDENT;
		out_len = tok_len;
		if (tok_len <= NAME_KEEP) begin
			for (int i = 0; i < KEYWORD_COUNT; i++) begin
				keyword_entry(i, txt, k);
				if (txt.len() == tok_len) begin
					hit = 1'b1;
					for (int j = 0; j < txt.len(); j++)
						if (txt[j] != name_chars[j]) hit = 1'b0;
					if (hit) begin
						found = k;
						// word forms of && and || report the symbol length
						out_len = (k == K_AND || k == K_OR) ? 8'd2 : tok_len;
					end
				end
			end
		end
		push_token(found, tok_line, tok_col, out_len);
	endfunction

	function automatic void flush_token();
		kind_t k;
		case (mode)
			SC_NUMBER: push_token(dot_seen ? K_FLOAT : K_INT, tok_line, tok_col, tok_len);
			SC_NAME:   finish_name();
			SC_STRING: push_token(K_STRING, tok_line, tok_col, tok_len);
			SC_OPERATOR:
				if (single_op(op_first, k)) push_token(k, tok_line, tok_col, 8'd1);
			default: ;
		endcase
		mode = SC_IDLE;
	endfunction

	function automatic void open_token(input logic [7:0] c, input logic [19:0] ln,
		input logic [15:0] cl);
		kind_t k;
		tok_line = ln;
		tok_col = cl;
		if (is_blank(c)) return;
		if (is_num(c)) begin
			mode = SC_NUMBER;
			tok_len = 8'd1;
			dot_seen = 1'b0;
		end else if (is_letter(c) || c == "_") begin
			mode = SC_NAME;
			name_chars[0] = c;
			tok_len = 8'd1;
		end else if (c == "#") begin
			mode = SC_COMMENT;
		end else if (c == "\"") begin
			mode = SC_STRING;
			tok_len = 8'd0;
		end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
			c == "&" || c == "|" || c == ">" || c == "<") begin
			mode = SC_OPERATOR;
			op_first = c;
		end else if (punct_token(c, k)) begin
			push_token(k, ln, cl, 8'd1);
		end
	endfunction

	// Advance the model by one accepted byte and queue the tokens it yields.
	function automatic void scan_byte(input logic [7:0] c, input logic eot);
		logic [19:0] ln;
		logic [15:0] cl;
		logic        taken;
		kind_t       k;
		int          count_in;
		count_in = token_q.size();
		taken = 1'b0;
		if (c == NL) begin
			if (cur_line != '1) cur_line++;
			ln = cur_line;
			cl = 16'd0;
			cur_col = 16'd1;
		end else begin
			ln = cur_line;
			cl = cur_col;
			if (cur_col != '1) cur_col++;
		end
		case (mode)
			SC_NUMBER:
				if (is_num(c)) begin
					bump_len();
					taken = 1'b1;
				end else if (c == "." && !dot_seen) begin
					dot_seen = 1'b1;
					bump_len();
					taken = 1'b1;
				end else flush_token();
			SC_NAME:
				if (is_letter(c) || is_num(c) || c == "_") begin
					if (tok_len < NAME_KEEP) name_chars[tok_len[2:0]] = c;
					bump_len();
					taken = 1'b1;
				end else flush_token();
			SC_STRING: begin
				if (c == "\"") flush_token();
				else bump_len();
				taken = 1'b1;
			end
			SC_COMMENT: begin
				if (c == NL) mode = SC_IDLE;
				taken = 1'b1;
			end
			SC_OPERATOR:
				if (pair_op(op_first, c, k)) begin
					push_token(k, tok_line, tok_col, 8'd2);
					mode = SC_IDLE;
					taken = 1'b1;
				end else flush_token();
			default: mode = SC_IDLE;
		endcase
		if (!taken) open_token(c, ln, cl);
		if (eot) begin
			flush_token();
			push_token(K_END, cur_line, cur_col, 8'd0);
			clear_scanner();
		end
		if (token_q.size() > count_in)
			token_q[token_q.size() - 1].last = 1'b1;
	endfunction

	// ---------------- stream side ----------------

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_beat
		token_exp_t want;
		logic       bad;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected token: kind %0d line %0d col %0d len %0d last %0b",
						m_tdata[5:0], m_tdata[25:6], m_tdata[41:26], m_tdata[49:42], m_tlast);
			end else begin
				want = token_q.pop_front();
				bad = m_tdata[5:0] != want.kind || m_tdata[25:6] != want.line ||
					m_tdata[41:26] != want.col || m_tdata[49:42] != want.len ||
					m_tdata[55:50] != 6'd0 || m_tlast != want.last;
				if (bad) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("token mismatch: expected kind %0d line %0d col %0d len %0d last %0b",
							want.kind, want.line, want.col, want.len, want.last);
						$display("   got kind %0d line %0d col %0d len %0d last %0b pad %0h",
							m_tdata[5:0], m_tdata[25:6], m_tdata[41:26], m_tdata[49:42],
							m_tlast, m_tdata[55:50]);
					end
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		scan_byte(c, eot);
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int j = 0; j < s.len(); j++)
			send_byte(s[j], close && j == s.len() - 1);
		idle_input();
	endtask

	task automatic wait_drain();
		while (token_q.size() != 0) @(posedge clk);
	endtask

	// ---------------- random text ----------------

	function automatic string op_text(input int i);
		case (i)
			0: return "+";   1: return "+=";  2: return "-";   3: return "-=";
			4: return "*";   5: return "*=";  6: return "/";   7: return "/=";
			8: return "=";   9: return "==";  10: return "&&"; 11: return "||";
			12: return "|";  13: return "|!"; 14: return ">";  15: return ">=";
			16: return "<";  17: return "<="; 18: return "&";  default: return "&=";
		endcase
	endfunction

	function automatic logic [7:0] word_char(input int top);
		int r;
		r = $urandom_range(0, top);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + (r - 26));
		if (r == 52) return "_";
		return 8'("0" + (r - 53));
	endfunction

	function automatic void add_char(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endfunction

	task automatic push_str(input string s);
		for (int j = 0; j < s.len(); j++) add_char(s[j]);
	endtask

	task automatic add_fragment();
		string txt;
		kind_t k;
		int    n;
		case ($urandom_range(0, 11))
			0, 1: begin
				keyword_entry($urandom_range(0, KEYWORD_COUNT - 1), txt, k);
				push_str(txt);
				// near miss: a keyword with one more word character
				if ($urandom_range(0, 3) == 0) add_char(word_char(62));
			end
			2: begin
				n = $urandom_range(1, 12);
				add_char(word_char(52));
				for (int j = 1; j < n; j++) add_char(word_char(62));
			end
			3: begin
				n = $urandom_range(1, 4);
				for (int j = 0; j < n; j++) add_char(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					add_char(".");
					for (int j = $urandom_range(0, 3); j > 0; j--)
						add_char(8'("0" + $urandom_range(0, 9)));
					if ($urandom_range(0, 3) == 0) add_char(".");
				end
			end
			4: begin
				add_char("\"");
				for (int j = $urandom_range(0, 8); j > 0; j--) begin
					n = $urandom_range(32, 126);
					add_char(n == 34 ? 8'h80 : n[7:0]);
				end
				if ($urandom_range(0, 5) != 0) add_char("\"");
			end
			5, 6: push_str(op_text($urandom_range(0, OP_COUNT - 1)));
			7: begin
				txt = "(){}[]:.!";
				add_char(txt[$urandom_range(0, 8)]);
			end
			8: begin
				n = $urandom_range(0, 5);
				add_char(n == 0 ? 8'h20 : 8'h08 + n[7:0]);
			end
			9: begin
				add_char("#");
				for (int j = $urandom_range(0, 6); j > 0; j--) begin
					n = $urandom_range(0, 255);
					add_char(n == NL ? 8'hFF : n[7:0]);
				end
				add_char(NL);
			end
			10: add_char(8'($urandom_range(0, 255)));
			default: add_char(" ");
		endcase
		if ($urandom_range(0, 1)) add_char(" ");
	endtask

	// ---------------- tests ----------------

	task automatic test_operators();
		send_text("+ += - -= * *= / /= = == && || | |! > >= < <= (){}[]:.! & x &&y |", 1'b1);
	endtask

	task automatic test_keywords();
		send_text({"var func if else elif and or type include return break continue ",
			"Vector2 Vector3 Vector4 true false const for while in null not\n",
			"continue_ Or"}, 1'b1);
	endtask

	task automatic test_numbers_strings();
		send_text("0 12 3.25 1.2.3 7. \"hi\" \"\" #c (\nab)", 1'b1);
		send_text("\"open", 1'b1);
		send_text("# t", 1'b1);
		send_text("x<", 1'b1);
	endtask

	task automatic test_byte_extremes();
		logic [7:0] raw [15];
		raw = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h09, 8'h0B, 8'h0C, 8'h0D,
			"#", 8'hFF, NL, "\"", 8'h80, "\"", 8'hFF};
		for (int j = 0; j < 15; j++) send_byte(raw[j], j == 14);
		idle_input();
	endtask

	task automatic test_backpressure();
		// hold the output long enough that the input side must stall
		hold_left = 60;
		send_text("((((((ab)", 1'b0);
		wait_drain();
		send_text("+=1 a|", 1'b1);
		wait_drain();
	endtask

	task automatic test_random();
		int idle_set [4];
		int stall_set [4];
		int sent;
		int n;
		idle_set = '{0, 50, 0, 22};
		stall_set = '{0, 0, 50, 22};
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			sent = 0;
			while (sent < 10) begin
				text_q.delete();
				n = $urandom_range(6, 14);
				while (text_q.size() < n) add_fragment();
				for (int j = 0; j < text_q.size(); j++)
					send_byte(text_q[j], j == text_q.size() - 1);
				sent += text_q.size();
			end
		end
		idle_input();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		fail_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		clear_scanner();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_keywords();
		test_numbers_strings();
		test_byte_extremes();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && token_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// ----- script_token_scanner_top.f -----
rtl/sts_pkg.sv
rtl/script_token_scanner_top.sv
sim/script_token_scanner_top_tb.sv
